@@ hw/rtl/ppob_pkg.sv @@
// ----------------------------------------------------------------------------
// ppob_pkg
// Types and constants shared by the order book core and its cells.
// ----------------------------------------------------------------------------
package ppob_pkg;

    localparam int BOOK_DEPTH = 64;
    localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CANCEL = 1'b1;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic        operation;
        logic        side;
        logic [31:0] price;
        logic [15:0] quantity;
        logic [30:0] order_id;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        bid_present;
        logic [31:0] bid_px;
        logic [15:0] bid_quantity;
        logic [30:0] bid_order;
        logic        ask_present;
        logic [31:0] ask_px;
        logic [15:0] ask_quantity;
        logic [30:0] ask_order;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] price;
        logic [15:0] quantity;
        logic [30:0] order_id;
    } entry_t;

    typedef struct packed {
        logic        ins;
        logic        del;
        logic [31:0] price;
        logic [15:0] quantity;
        logic [30:0] order_id;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/ppob_cell.sv @@
// ----------------------------------------------------------------------------
// ppob_cell
// One slot of a sorted side chain; shifts down on insert, up on removal.
// ----------------------------------------------------------------------------
module ppob_cell
    import ppob_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       is_buy,
    input  cell_ctrl_t ctrl,
    input  logic       shift,
    input  entry_t     prev_entry,
    input  logic       prev_ahead,
    input  entry_t     next_entry,
    output entry_t     entry,
    output logic       ahead,
    output logic       match
);

    logic   valid_reg;
    logic   valid_next;
    entry_t data_reg;
    entry_t data_next;
    logic   load;
    logic   precedes;

    assign entry = '{valid: valid_reg, price: data_reg.price,
                     quantity: data_reg.quantity, order_id: data_reg.order_id};

    // buy: higher price first, newest first on ties; sell: lower first, oldest first
    assign precedes = is_buy ? (ctrl.price >= data_reg.price)
                             : (ctrl.price < data_reg.price);
    assign ahead    = !valid_reg || precedes;
    assign match    = valid_reg && (data_reg.order_id == ctrl.order_id);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        load       = 1'b0;
        if (ctrl.ins)
        begin
            load = 1'b1;
            if (prev_ahead)
            begin
                data_next  = prev_entry;
                valid_next = prev_entry.valid;
            end
            else if (ahead)
            begin
                data_next  = '{valid: 1'b1, price: ctrl.price,
                              quantity: ctrl.quantity, order_id: ctrl.order_id};
                valid_next = 1'b1;
            end
            else
            begin
                load = 1'b0;
            end
        end
        else if (ctrl.del && shift)
        begin
            load       = 1'b1;
            data_next  = next_entry;
            valid_next = next_entry.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ hw/rtl/price_priority_order_book_core.sv @@
// ----------------------------------------------------------------------------
// price_priority_order_book_core
// Two sorted chains of cells holding resting orders; reports top of book.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a request word and pulse start while busy is low; the word is
//   taken at that clock edge and busy rises on the next cycle.
//   An insert is placed in sorted position in the chain of its side; a
//   cancel removes one order by id, buy chain first. The head cell of each
//   chain is the best bid or ask.
//   Each request gives one result word, shown on result for exactly one
//   cycle while done is high; the receiver cannot stall it.
//   Steps: the id match of all cells is registered in S_MATCH, the chains
//   shift in S_APPLY, the result is shown in S_REPORT, and the next request
//   is taken back in S_IDLE; a new request is not taken until the last one
//   has been reported.
//   Reset empties both chains and the order count; no clearing pass.
// ----------------------------------------------------------------------------
module price_priority_order_book_core
    import ppob_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    output logic     busy,
    output logic     done,
    output result_t  result
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MATCH  = 2'd1;
    localparam logic [1:0] S_APPLY  = 2'd2;
    localparam logic [1:0] S_REPORT = 2'd3;

    logic [1:0]            state_reg, state_next;
    request_t              req_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [1:0]            status_reg, status_next;
    logic [BOOK_DEPTH-1:0] buy_m_reg, sell_m_reg;

    entry_t                buy_e  [BOOK_DEPTH];
    entry_t                sell_e [BOOK_DEPTH];
    logic [BOOK_DEPTH-1:0] buy_ahead, sell_ahead, buy_match, sell_match;
    logic [BOOK_DEPTH-1:0] buy_shift, sell_shift;
    cell_ctrl_t            buy_ctrl, sell_ctrl;
    logic                  accept;
    logic                  full;

    assign accept = start && !busy;
    assign busy   = state_reg != S_IDLE;
    assign full   = count_reg == CNT_W'(BOOK_DEPTH);

    // buy chain: last match goes; sell chain: first match goes
    always_comb
    begin
        for (int i = 0; i < BOOK_DEPTH; i++)
        begin
            buy_shift[i]  = 1'b1;
            sell_shift[i] = 1'b0;
            for (int j = 0; j < BOOK_DEPTH; j++)
            begin
                if (j > i && buy_m_reg[j])
                begin
                    buy_shift[i] = 1'b0;
                end
                if (j <= i && sell_m_reg[j])
                begin
                    sell_shift[i] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        buy_ctrl          = '{ins: 1'b0, del: 1'b0, price: req_reg.price,
                              quantity: req_reg.quantity, order_id: req_reg.order_id};
        sell_ctrl         = buy_ctrl;
        state_next        = state_reg;
        count_next        = count_reg;
        status_next       = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next  = S_REPORT;
                status_next = ST_DONE;
                if (req_reg.operation == OP_INSERT)
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        buy_ctrl.ins  = req_reg.side;
                        sell_ctrl.ins = !req_reg.side;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                else if (|buy_m_reg)
                begin
                    buy_ctrl.del = 1'b1;
                    count_next   = count_reg - CNT_W'(1);
                end
                else if (|sell_m_reg)
                begin
                    sell_ctrl.del = 1'b1;
                    count_next    = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            S_REPORT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < BOOK_DEPTH; g++)
        begin : g_cells
            entry_t buy_prev, sell_prev, buy_nx, sell_nx;
            logic   buy_pa, sell_pa;
            if (g == 0)
            begin : g_head
                assign buy_prev  = '0;
                assign sell_prev = '0;
                assign buy_pa    = 1'b0;
                assign sell_pa   = 1'b0;
            end
            else
            begin : g_body
                assign buy_prev  = buy_e[g-1];
                assign sell_prev = sell_e[g-1];
                assign buy_pa    = buy_ahead[g-1];
                assign sell_pa   = sell_ahead[g-1];
            end
            if (g == BOOK_DEPTH - 1)
            begin : g_tail
                assign buy_nx  = '0;
                assign sell_nx = '0;
            end
            else
            begin : g_mid
                assign buy_nx  = buy_e[g+1];
                assign sell_nx = sell_e[g+1];
            end

            ppob_cell u_buy (
                .clk         (clk),
                .rst_n       (rst_n),
                .is_buy      (1'b1),
                .ctrl        (buy_ctrl),
                .shift       (buy_shift[g]),
                .prev_entry  (buy_prev),
                .prev_ahead  (buy_pa),
                .next_entry  (buy_nx),
                .entry       (buy_e[g]),
                .ahead       (buy_ahead[g]),
                .match       (buy_match[g])
            );

            ppob_cell u_sell (
                .clk         (clk),
                .rst_n       (rst_n),
                .is_buy      (1'b0),
                .ctrl        (sell_ctrl),
                .shift       (sell_shift[g]),
                .prev_entry  (sell_prev),
                .prev_ahead  (sell_pa),
                .next_entry  (sell_nx),
                .entry       (sell_e[g]),
                .ahead       (sell_ahead[g]),
                .match       (sell_match[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (accept)
        begin
            req_reg <= request;
        end
        if (state_reg == S_MATCH)
        begin
            buy_m_reg  <= buy_match;
            sell_m_reg <= sell_match;
        end
    end

    assign done = state_reg == S_REPORT;

    always_comb
    begin
        result              = '0;
        result.status       = status_reg;
        result.bid_present  = buy_e[0].valid;
        result.ask_present  = sell_e[0].valid;
        if (buy_e[0].valid)
        begin
            result.bid_px       = buy_e[0].price;
            result.bid_quantity = buy_e[0].quantity;
            result.bid_order    = buy_e[0].order_id;
        end
        if (sell_e[0].valid)
        begin
            result.ask_px       = sell_e[0].price;
            result.ask_quantity = sell_e[0].quantity;
            result.ask_order    = sell_e[0].order_id;
        end
    end

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !done)
        else $error("accepted word did not make the core busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(BOOK_DEPTH))
        else $error("order count beyond book depth");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_DONE || result.status == ST_FULL ||
                  result.status == ST_NOT_FOUND))
        else $error("bad status code");

    a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY && status_next == ST_FULL) |=> $stable(count_reg))
        else $error("dropped insert changed the count");

endmodule
